// ----- hdl/cpq_pkg.sv -----
// Shared widths and register codes for the capsule point query block.
// No dependencies; every other file imports this package.
`default_nettype none

package cpq_pkg;

    localparam int COORD_BITS = 24;

    localparam int CW   = COORD_BITS;
    localparam int DW   = CW + 1;
    localparam int RADW = CW - 1;
    localparam int L2W  = 2 * CW + 1;
    localparam int DOTW = 2 * CW + 2;
    localparam int NW   = L2W + CW;
    localparam int QX   = CW;
    localparam int LW   = 2 * CW + 2;
    localparam int SQ   = CW + 1;
    localparam int RW   = SQ + 2;
    localparam int SW   = 2 * CW;
    localparam int QS   = CW - 1;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X = 3'd0,
        CFG_START_Y = 3'd1,
        CFG_END_X   = 3'd2,
        CFG_END_Y   = 3'd3,
        CFG_RADIUS  = 3'd4
    } t_cfg_idx;

endpackage

`default_nettype wire

// ----- hdl/cpq_query_if.sv -----
// Query point channel: valid/ready handshake with the point coordinates.
// Depends on cpq_pkg.
`default_nettype none

interface cpq_query_if;
    import cpq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] query_x;
    logic signed [CW-1:0] query_y;

    modport source (output valid, output query_x, output query_y, input ready);
    modport sink   (input valid, input query_x, input query_y, output ready);
endinterface

`default_nettype wire

// ----- hdl/cpq_result_if.sv -----
// Result channel: valid/ready handshake with inside flag and nearest point.
// Depends on cpq_pkg.
`default_nettype none

interface cpq_result_if;
    import cpq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 is_inside;
    logic signed [CW-1:0] near_x;
    logic signed [CW-1:0] near_y;

    modport source (output valid, output is_inside, output near_x, output near_y,
                    input ready);
    modport sink   (input valid, input is_inside, input near_x, input near_y,
                    output ready);
endinterface

`default_nettype wire

// ----- hdl/capsule_point_query_2d.sv -----
// Closest point on a 2D capsule: projection, pipelined dividers and square root.
// Depends on cpq_pkg, cpq_query_if and cpq_result_if.
//
// Usage:
//   Write the segment start, segment end and radius through the config port
//   (i_cfg_we, i_cfg_idx, i_cfg_data) while no query is in flight.
//   Send query points on i_query; one transfer per point. Each point yields
//   exactly one transfer on o_result: inside flag and nearest capsule point.
//   Throughput is one point per cycle while o_result is not stalled. The
//   pipeline runs through the projection divider (one quotient bit per
//   stage), the square root (one root bit per stage) and the clamp divider.
//   A stalled result holds in the output register and freezes the whole
//   pipeline; i_query.ready drops until o_result.ready returns. Nothing is
//   lost or repeated. Reset clears the config registers to zero and empties
//   the pipeline.
`default_nettype none

module capsule_point_query_2d (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [cpq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [cpq_pkg::CW-1:0]        i_cfg_data,
    cpq_query_if.sink                          i_query,
    cpq_result_if.source                       o_result
);
    import cpq_pkg::*;

    typedef enum logic [1:0] {BASE_START, BASE_END, BASE_MID} t_base;

    typedef struct packed {
        logic signed [CW-1:0] qx;
        logic signed [CW-1:0] qy;
        t_base                mode;
        logic [L2W-1:0]       l2;
        logic [L2W-1:0]       remx;
        logic [L2W-1:0]       remy;
        logic [QX-1:0]        lowx;
        logic [QX-1:0]        lowy;
    } t_div;

    typedef struct packed {
        logic                 hit;
        logic                 clamp;
        logic                 sgnx;
        logic                 sgny;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] qx;
        logic signed [CW-1:0] qy;
        logic [SW-1:0]        nx;
        logic [SW-1:0]        ny;
        logic [RW-1:0]        rem;
        logic [SQ-1:0]        root;
        logic [LW-1:0]        rad;
    } t_sq;

    typedef struct packed {
        logic                 hit;
        logic                 clamp;
        logic                 sgnx;
        logic                 sgny;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] qx;
        logic signed [CW-1:0] qy;
        logic [SQ-1:0]        len;
        logic [SQ-1:0]        remx;
        logic [SQ-1:0]        remy;
        logic [QS-1:0]        lowx;
        logic [QS-1:0]        lowy;
    } t_sc;

    function automatic logic [L2W+QX-1:0] div_step(
        input logic [L2W-1:0] rem,
        input logic [QX-1:0]  low,
        input logic [L2W-1:0] den
    );
        logic [L2W:0] t;
        logic [L2W:0] d;
        t = {rem, low[QX-1]};
        d = t - {1'b0, den};
        if (t >= {1'b0, den}) begin
            div_step = {d[L2W-1:0], low[QX-2:0], 1'b1};
        end else begin
            div_step = {t[L2W-1:0], low[QX-2:0], 1'b0};
        end
    endfunction

    function automatic logic [SQ+QS-1:0] scl_step(
        input logic [SQ-1:0] rem,
        input logic [QS-1:0] low,
        input logic [SQ-1:0] den
    );
        logic [SQ:0] t;
        logic [SQ:0] d;
        t = {rem, low[QS-1]};
        d = t - {1'b0, den};
        if (t >= {1'b0, den}) begin
            scl_step = {d[SQ-1:0], low[QS-2:0], 1'b1};
        end else begin
            scl_step = {t[SQ-1:0], low[QS-2:0], 1'b0};
        end
    endfunction

    function automatic logic [RW+SQ+LW-1:0] sq_step(
        input logic [RW-1:0] rem,
        input logic [SQ-1:0] root,
        input logic [LW-1:0] rad
    );
        logic [RW+1:0] t;
        logic [RW+1:0] trial;
        logic [RW+1:0] d;
        t     = {rem, rad[LW-1 -: 2]};
        trial = (RW+2)'({root, 2'b01});
        d     = t - trial;
        if (t >= trial) begin
            sq_step = {d[RW-1:0], root[SQ-2:0], 1'b1, rad[LW-3:0], 2'b00};
        end else begin
            sq_step = {t[RW-1:0], root[SQ-2:0], 1'b0, rad[LW-3:0], 2'b00};
        end
    endfunction

    function automatic logic signed [CW-1:0] sat(input logic signed [CW:0] v);
        if (v[CW] != v[CW-1]) begin
            sat = v[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end else begin
            sat = v[CW-1:0];
        end
    endfunction

    // configuration registers
    logic signed [CW-1:0] r_start_x, r_start_y, r_end_x, r_end_y;
    logic [RADW-1:0]      r_cap_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x    <= '0;
            r_start_y    <= '0;
            r_end_x      <= '0;
            r_end_y      <= '0;
            r_cap_radius <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_X: r_start_x    <= i_cfg_data;
                CFG_START_Y: r_start_y    <= i_cfg_data;
                CFG_END_X:   r_end_x      <= i_cfg_data;
                CFG_END_Y:   r_end_y      <= i_cfg_data;
                CFG_RADIUS:  r_cap_radius <= i_cfg_data[RADW-1:0];
                default: ;
            endcase
        end
    end

    logic signed [DW-1:0] dx, dy, dxn, dyn;
    logic [CW-1:0]        adx, ady;
    logic                 en;

    assign dx  = DW'(r_end_x) - DW'(r_start_x);
    assign dy  = DW'(r_end_y) - DW'(r_start_y);
    assign dxn = -dx;
    assign dyn = -dy;
    assign adx = dx[DW-1] ? dxn[CW-1:0] : dx[CW-1:0];
    assign ady = dy[DW-1] ? dyn[CW-1:0] : dy[CW-1:0];

    assign en            = !o_result.valid || o_result.ready;
    assign i_query.ready = en;

    // stage 1: offsets from start
    logic                 r_s1_v;
    logic signed [CW-1:0] r_s1_qx, r_s1_qy;
    logic signed [DW-1:0] r_s1_rx, r_s1_ry;

    // stage 2: products
    logic                   r_s2_v;
    logic signed [CW-1:0]   r_s2_qx, r_s2_qy;
    logic [2*DW-1:0]        r_s2_dxx, r_s2_dyy;
    logic signed [2*DW-1:0] r_s2_dxr, r_s2_dyr;

    // stage 3: squared length and dot product
    logic                   r_s3_v;
    logic signed [CW-1:0]   r_s3_qx, r_s3_qy;
    logic [L2W-1:0]         r_s3_l2;
    logic signed [DOTW-1:0] r_s3_dot;

    // stage 4: base selection and numerator partial products
    logic                 r_s4_v;
    logic signed [CW-1:0] r_s4_qx, r_s4_qy;
    t_base                r_s4_mode;
    logic [L2W-1:0]       r_s4_l2;
    logic [DW+CW-1:0]     r_s4_pxl, r_s4_pyl;
    logic [2*CW-1:0]      r_s4_pxh, r_s4_pyh;

    logic [L2W-1:0] dot_u;
    logic           dot_pos;
    t_base          n_mode;
    logic [NW-1:0]  num_x, num_y;

    assign dot_u   = r_s3_dot[L2W-1:0];
    assign dot_pos = !r_s3_dot[DOTW-1] && (r_s3_dot != '0);
    assign num_x   = (NW'(r_s4_pxh) << DW) + NW'(r_s4_pxl);
    assign num_y   = (NW'(r_s4_pyh) << DW) + NW'(r_s4_pyl);

    always_comb begin
        if (r_s3_l2 == '0 || !dot_pos) begin
            n_mode = BASE_START;
        end else if (dot_u >= r_s3_l2) begin
            n_mode = BASE_END;
        end else begin
            n_mode = BASE_MID;
        end
    end

    logic r_div_v [QX+1];
    t_div r_div   [QX+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_s3_v    <= 1'b0;
            r_s4_v    <= 1'b0;
            r_div_v[0] <= 1'b0;
        end else if (en) begin
            r_s1_v    <= i_query.valid;
            r_s2_v    <= r_s1_v;
            r_s3_v    <= r_s2_v;
            r_s4_v    <= r_s3_v;
            r_div_v[0] <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_qx <= i_query.query_x;
            r_s1_qy <= i_query.query_y;
            r_s1_rx <= DW'(i_query.query_x) - DW'(r_start_x);
            r_s1_ry <= DW'(i_query.query_y) - DW'(r_start_y);

            r_s2_qx  <= r_s1_qx;
            r_s2_qy  <= r_s1_qy;
            r_s2_dxx <= dx * dx;
            r_s2_dyy <= dy * dy;
            r_s2_dxr <= dx * r_s1_rx;
            r_s2_dyr <= dy * r_s1_ry;

            r_s3_qx  <= r_s2_qx;
            r_s3_qy  <= r_s2_qy;
            r_s3_l2  <= L2W'(r_s2_dxx + r_s2_dyy);
            r_s3_dot <= r_s2_dxr + r_s2_dyr;

            r_s4_qx   <= r_s3_qx;
            r_s4_qy   <= r_s3_qy;
            r_s4_mode <= n_mode;
            r_s4_l2   <= r_s3_l2;
            r_s4_pxl  <= dot_u[DW-1:0] * adx;
            r_s4_pyl  <= dot_u[DW-1:0] * ady;
            r_s4_pxh  <= dot_u[L2W-1:DW] * adx;
            r_s4_pyh  <= dot_u[L2W-1:DW] * ady;

            r_div[0].qx   <= r_s4_qx;
            r_div[0].qy   <= r_s4_qy;
            r_div[0].mode <= r_s4_mode;
            r_div[0].l2   <= r_s4_l2;
            r_div[0].remx <= num_x[NW-1:QX];
            r_div[0].remy <= num_y[NW-1:QX];
            r_div[0].lowx <= num_x[QX-1:0];
            r_div[0].lowy <= num_y[QX-1:0];
        end
    end

    // projection divider: one quotient bit per stage
    for (genvar k = 0; k < QX; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div_v[k+1] <= 1'b0;
            end else if (en) begin
                r_div_v[k+1] <= r_div_v[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_div[k+1].qx   <= r_div[k].qx;
                r_div[k+1].qy   <= r_div[k].qy;
                r_div[k+1].mode <= r_div[k].mode;
                r_div[k+1].l2   <= r_div[k].l2;
                {r_div[k+1].remx, r_div[k+1].lowx} <=
                    div_step(r_div[k].remx, r_div[k].lowx, r_div[k].l2);
                {r_div[k+1].remy, r_div[k+1].lowy} <=
                    div_step(r_div[k].remy, r_div[k].lowy, r_div[k].l2);
            end
        end
    end

    // stage A: base point and offset
    logic signed [DW-1:0] pxs, pys, bxm, bym;
    logic signed [CW-1:0] n_bx, n_by;

    assign pxs = $signed({1'b0, r_div[QX].lowx});
    assign pys = $signed({1'b0, r_div[QX].lowy});
    assign bxm = DW'(r_start_x) + (dx[DW-1] ? -pxs : pxs);
    assign bym = DW'(r_start_y) + (dy[DW-1] ? -pys : pys);

    always_comb begin
        case (r_div[QX].mode)
            BASE_END: begin
                n_bx = r_end_x;
                n_by = r_end_y;
            end
            BASE_MID: begin
                n_bx = bxm[CW-1:0];
                n_by = bym[CW-1:0];
            end
            default: begin
                n_bx = r_start_x;
                n_by = r_start_y;
            end
        endcase
    end

    logic                 r_a_v;
    logic signed [CW-1:0] r_a_qx, r_a_qy, r_a_bx, r_a_by;
    logic signed [DW-1:0] r_a_ox, r_a_oy, a_oxn, a_oyn;
    logic [DW-1:0]        a_aox, a_aoy;

    assign a_oxn = -r_a_ox;
    assign a_oyn = -r_a_oy;
    assign a_aox = r_a_ox[DW-1] ? a_oxn : r_a_ox;
    assign a_aoy = r_a_oy[DW-1] ? a_oyn : r_a_oy;

    // stage B: squared offset, squared radius, clamp numerators
    logic                 r_b_v;
    logic signed [CW-1:0] r_b_qx, r_b_qy, r_b_bx, r_b_by;
    logic                 r_b_sgnx, r_b_sgny;
    logic [2*DW-1:0]      r_b_sqx, r_b_sqy;
    logic [2*RADW-1:0]    r_b_r2;
    logic [SW-1:0]        r_b_nx, r_b_ny;

    logic [LW-1:0] len2, r2;

    assign len2 = LW'(r_b_sqx) + LW'(r_b_sqy);
    assign r2   = LW'(r_b_r2);

    logic r_sq_v [SQ+1];
    t_sq  r_sq   [SQ+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v     <= 1'b0;
            r_b_v     <= 1'b0;
            r_sq_v[0] <= 1'b0;
        end else if (en) begin
            r_a_v     <= r_div_v[QX];
            r_b_v     <= r_a_v;
            r_sq_v[0] <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_qx <= r_div[QX].qx;
            r_a_qy <= r_div[QX].qy;
            r_a_bx <= n_bx;
            r_a_by <= n_by;
            r_a_ox <= DW'(r_div[QX].qx) - DW'(n_bx);
            r_a_oy <= DW'(r_div[QX].qy) - DW'(n_by);

            r_b_qx   <= r_a_qx;
            r_b_qy   <= r_a_qy;
            r_b_bx   <= r_a_bx;
            r_b_by   <= r_a_by;
            r_b_sgnx <= r_a_ox[DW-1];
            r_b_sgny <= r_a_oy[DW-1];
            r_b_sqx  <= r_a_ox * r_a_ox;
            r_b_sqy  <= r_a_oy * r_a_oy;
            r_b_r2   <= r_cap_radius * r_cap_radius;
            r_b_nx   <= a_aox * r_cap_radius;
            r_b_ny   <= a_aoy * r_cap_radius;

            r_sq[0].hit    <= len2 < r2;
            r_sq[0].clamp  <= len2 > r2;
            r_sq[0].sgnx   <= r_b_sgnx;
            r_sq[0].sgny   <= r_b_sgny;
            r_sq[0].bx     <= r_b_bx;
            r_sq[0].by     <= r_b_by;
            r_sq[0].qx     <= r_b_qx;
            r_sq[0].qy     <= r_b_qy;
            r_sq[0].nx     <= r_b_nx;
            r_sq[0].ny     <= r_b_ny;
            r_sq[0].rem    <= '0;
            r_sq[0].root   <= '0;
            r_sq[0].rad    <= len2;
        end
    end

    // square root: one root bit per stage
    for (genvar k = 0; k < SQ; k++) begin : g_sq
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else if (en) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq[k+1].hit    <= r_sq[k].hit;
                r_sq[k+1].clamp  <= r_sq[k].clamp;
                r_sq[k+1].sgnx   <= r_sq[k].sgnx;
                r_sq[k+1].sgny   <= r_sq[k].sgny;
                r_sq[k+1].bx     <= r_sq[k].bx;
                r_sq[k+1].by     <= r_sq[k].by;
                r_sq[k+1].qx     <= r_sq[k].qx;
                r_sq[k+1].qy     <= r_sq[k].qy;
                r_sq[k+1].nx     <= r_sq[k].nx;
                r_sq[k+1].ny     <= r_sq[k].ny;
                {r_sq[k+1].rem, r_sq[k+1].root, r_sq[k+1].rad} <=
                    sq_step(r_sq[k].rem, r_sq[k].root, r_sq[k].rad);
            end
        end
    end

    logic r_sc_v [QS+1];
    t_sc  r_sc   [QS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_v[0] <= 1'b0;
        end else if (en) begin
            r_sc_v[0] <= r_sq_v[SQ];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sc[0].hit    <= r_sq[SQ].hit;
            r_sc[0].clamp  <= r_sq[SQ].clamp;
            r_sc[0].sgnx   <= r_sq[SQ].sgnx;
            r_sc[0].sgny   <= r_sq[SQ].sgny;
            r_sc[0].bx     <= r_sq[SQ].bx;
            r_sc[0].by     <= r_sq[SQ].by;
            r_sc[0].qx     <= r_sq[SQ].qx;
            r_sc[0].qy     <= r_sq[SQ].qy;
            r_sc[0].len    <= r_sq[SQ].root;
            r_sc[0].remx   <= r_sq[SQ].nx[SW-1:QS];
            r_sc[0].remy   <= r_sq[SQ].ny[SW-1:QS];
            r_sc[0].lowx   <= r_sq[SQ].nx[QS-1:0];
            r_sc[0].lowy   <= r_sq[SQ].ny[QS-1:0];
        end
    end

    // clamp divider: offset * radius / length
    for (genvar k = 0; k < QS; k++) begin : g_sc
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sc_v[k+1] <= 1'b0;
            end else if (en) begin
                r_sc_v[k+1] <= r_sc_v[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sc[k+1].hit    <= r_sc[k].hit;
                r_sc[k+1].clamp  <= r_sc[k].clamp;
                r_sc[k+1].sgnx   <= r_sc[k].sgnx;
                r_sc[k+1].sgny   <= r_sc[k].sgny;
                r_sc[k+1].bx     <= r_sc[k].bx;
                r_sc[k+1].by     <= r_sc[k].by;
                r_sc[k+1].qx     <= r_sc[k].qx;
                r_sc[k+1].qy     <= r_sc[k].qy;
                r_sc[k+1].len    <= r_sc[k].len;
                {r_sc[k+1].remx, r_sc[k+1].lowx} <=
                    scl_step(r_sc[k].remx, r_sc[k].lowx, r_sc[k].len);
                {r_sc[k+1].remy, r_sc[k+1].lowy} <=
                    scl_step(r_sc[k].remy, r_sc[k].lowy, r_sc[k].len);
            end
        end
    end

    // output stage
    logic signed [CW:0] mx, my, ofsx, ofsy, sumx, sumy;

    assign mx   = $signed({2'b00, r_sc[QS].lowx});
    assign my   = $signed({2'b00, r_sc[QS].lowy});
    assign ofsx = r_sc[QS].sgnx ? -mx : mx;
    assign ofsy = r_sc[QS].sgny ? -my : my;
    assign sumx = {r_sc[QS].bx[CW-1], r_sc[QS].bx} + ofsx;
    assign sumy = {r_sc[QS].by[CW-1], r_sc[QS].by} + ofsy;

    logic                 r_out_v, r_out_inside;
    logic signed [CW-1:0] r_out_nx, r_out_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_sc_v[QS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_inside <= r_sc[QS].hit;
            r_out_nx     <= r_sc[QS].clamp ? sat(sumx) : r_sc[QS].qx;
            r_out_ny     <= r_sc[QS].clamp ? sat(sumy) : r_sc[QS].qy;
        end
    end

    assign o_result.valid     = r_out_v;
    assign o_result.is_inside = r_out_inside;
    assign o_result.near_x    = r_out_nx;
    assign o_result.near_y    = r_out_ny;

endmodule

`default_nettype wire
